@@ src/kcfc_pkg.sv @@
// Package: shared types, constants and register indexes for the kicker controller.
`default_nettype none
package kcfc_pkg;

  localparam int unsigned AdcBits     = 12;
  localparam int unsigned CdBits      = 24;
  localparam int unsigned StrBits     = 8;
  localparam int unsigned UnitBits    = 16;
  localparam int unsigned PulseBits   = 20;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned ProdBits    = StrBits + UnitBits;

  // strength is Q4.4, anything below 1.0 counts as 1.0
  localparam logic [StrBits-1:0] StrOne = StrBits'(16);

  localparam logic [CfgIdxBits-1:0] CFG_BALL_IR_LEVEL   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_FIRE_LOAD   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_CHARGE_LOAD = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_COOLDOWN_TICKS  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_PULSE_UNIT      = 3'd4;

  localparam logic [AdcBits-1:0]  BallIrLevelRst   = AdcBits'(2048);
  localparam logic [AdcBits-1:0]  MinFireLoadRst   = AdcBits'(1024);
  localparam logic [AdcBits-1:0]  MaxChargeLoadRst = AdcBits'(3072);
  localparam logic [CdBits-1:0]   CooldownRst      = CdBits'(500000);
  localparam logic [UnitBits-1:0] PulseUnitRst     = UnitBits'(1000);

  typedef struct packed {
    logic                cmd_valid;
    logic                cmd_front;
    logic                cmd_chip;
    logic                cmd_charge;
    logic                cmd_bypass_ir;
    logic [StrBits-1:0]  cmd_strength;
    logic [AdcBits-1:0]  ir_sample;
    logic [AdcBits-1:0]  load_sample;
  } item_t;

  typedef struct packed {
    logic charge_on;
    logic front_drive;
    logic chip_drive;
    logic ball_seen;
    logic kick_fired;
    logic pulse_busy;
  } result_t;

  typedef struct packed {
    logic [AdcBits-1:0]  ball_ir_level;
    logic [AdcBits-1:0]  min_fire_load;
    logic [AdcBits-1:0]  max_charge_load;
    logic [CdBits-1:0]   cooldown_ticks;
    logic [UnitBits-1:0] pulse_unit_ticks;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/kcfc_cfg_regs.sv @@
// Configuration register file written through the plain write port.
`default_nettype none
module kcfc_cfg_regs (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [kcfc_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  wire  [kcfc_pkg::CfgDataBits-1:0]      cfg_wdata_i,
  output kcfc_pkg::cfg_t                        cfg_o
);
  import kcfc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ball_ir_level    <= BallIrLevelRst;
      cfg_q.min_fire_load    <= MinFireLoadRst;
      cfg_q.max_charge_load  <= MaxChargeLoadRst;
      cfg_q.cooldown_ticks   <= CooldownRst;
      cfg_q.pulse_unit_ticks <= PulseUnitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BALL_IR_LEVEL:   cfg_q.ball_ir_level    <= cfg_wdata_i[AdcBits-1:0];
        CFG_MIN_FIRE_LOAD:   cfg_q.min_fire_load    <= cfg_wdata_i[AdcBits-1:0];
        CFG_MAX_CHARGE_LOAD: cfg_q.max_charge_load  <= cfg_wdata_i[AdcBits-1:0];
        CFG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks   <= cfg_wdata_i[CdBits-1:0];
        CFG_PULSE_UNIT:      cfg_q.pulse_unit_ticks <= cfg_wdata_i[UnitBits-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ src/kcfc_core.sv @@
// Kick state (pending requests, cooldown, pulse counter) and per-tick decision logic.
`default_nettype none
module kcfc_core (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                step_i,
  input  kcfc_pkg::item_t    item_i,
  input  kcfc_pkg::cfg_t     cfg_i,
  output kcfc_pkg::result_t  res_o
);
  import kcfc_pkg::*;

  logic                 front_q, front_d;
  logic                 chip_q, chip_d;
  logic                 charge_q, charge_d;
  logic                 bypass_q, bypass_d;
  logic [StrBits-1:0]   str_q, str_d;
  logic [CdBits-1:0]    cd_q, cd_d;
  logic [PulseBits-1:0] pulse_q, pulse_d;
  logic                 is_front_q, is_front_d;

  logic                 ball;
  logic                 load_ok;
  logic                 below_max;
  logic                 cd_ok;
  logic [StrBits-1:0]   str_eff;
  logic [ProdBits-1:0]  prod;
  logic [PulseBits-1:0] len;
  result_t              res;

  assign ball      = item_i.ir_sample < cfg_i.ball_ir_level;
  assign load_ok   = item_i.load_sample > cfg_i.min_fire_load;
  assign below_max = item_i.load_sample < cfg_i.max_charge_load;
  assign cd_ok     = cd_q > cfg_i.cooldown_ticks;

  always_comb begin
    front_d    = front_q;
    chip_d     = chip_q;
    charge_d   = charge_q;
    bypass_d   = bypass_q;
    str_d      = str_q;
    is_front_d = is_front_q;
    pulse_d    = pulse_q;
    res        = '0;
    res.ball_seen = ball;

    // a command replaces the pending flags before this tick is evaluated
    if (item_i.cmd_valid) begin
      front_d  = item_i.cmd_front;
      chip_d   = item_i.cmd_chip;
      charge_d = item_i.cmd_charge;
      bypass_d = item_i.cmd_bypass_ir;
      str_d    = item_i.cmd_strength;
    end

    str_eff = (str_d < StrOne) ? StrOne : str_d;
    prod    = ProdBits'(str_eff) * ProdBits'(cfg_i.pulse_unit_ticks);
    len     = prod[ProdBits-1:4];

    cd_d = (cd_q != '1) ? cd_q + CdBits'(1) : cd_q;

    if (pulse_q != '0) begin
      res.pulse_busy  = 1'b1;
      res.front_drive = is_front_q;
      res.chip_drive  = !is_front_q;
      pulse_d         = pulse_q - PulseBits'(1);
    end else if (front_d || chip_d) begin
      if ((ball || bypass_d) && load_ok && cd_ok) begin
        is_front_d      = front_d;
        res.kick_fired  = 1'b1;
        res.pulse_busy  = 1'b1;
        res.front_drive = front_d;
        res.chip_drive  = !front_d;
        // start tick is the first tick of the pulse
        pulse_d         = (len != '0) ? len - PulseBits'(1) : '0;
        cd_d            = '0;
        front_d         = 1'b0;
        chip_d          = 1'b0;
        charge_d        = 1'b0;
      end else begin
        res.charge_on = below_max;
      end
    end else if (charge_d) begin
      res.charge_on = below_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= 1'b0;
      chip_q     <= 1'b0;
      charge_q   <= 1'b0;
      bypass_q   <= 1'b0;
      str_q      <= '0;
      cd_q       <= '0;
      pulse_q    <= '0;
      is_front_q <= 1'b0;
    end else if (step_i) begin
      front_q    <= front_d;
      chip_q     <= chip_d;
      charge_q   <= charge_d;
      bypass_q   <= bypass_d;
      str_q      <= str_d;
      cd_q       <= cd_d;
      pulse_q    <= pulse_d;
      is_front_q <= is_front_d;
    end
  end

  assign res_o = res;

endmodule
`default_nettype wire

@@ src/kicker_charge_and_fire_control.sv @@
// Kicker charge and fire control: top level with input and result registers.
//
// One input beat per 1 us tick carries an optional command plus the IR and
// capacitor-load samples; every input beat yields exactly one result beat
// (charger enable, solenoid drives, ball seen, kick fired, pulse busy).
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// An accepted beat lands in the input register, is evaluated from there and
// its result is loaded into the result register once that register is free.
// Throughput: one beat per cycle while the receiver does not stall; the
// pending flags, cooldown and pulse counters update with each evaluated beat,
// so the next tick may follow directly.
// When the receiver stalls, the result register holds and the input register
// keeps taking one more beat; after that in_stall_o rises until the result
// drains. Configuration writes go to cfg_idx_i 0..4 and take effect at once.
// Reset clears all pending requests, the cooldown count (so no kick fires
// until cooldown_ticks is exceeded) and any pulse; registers return to their
// defaults.
`default_nettype none
module kicker_charge_and_fire_control (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  kcfc_pkg::item_t                    in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output kcfc_pkg::result_t                  out_data_o,
  input  wire                                cfg_we_i,
  input  wire  [kcfc_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  wire  [kcfc_pkg::CfgDataBits-1:0]   cfg_wdata_i
);
  import kcfc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    out_free;
  logic    step;
  logic    in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  kcfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kcfc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

`ifndef NO_ASSERTIONS
  a_fire_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kick_fired |-> out_data_o.pulse_busy)
    else $error("kick fired without pulse busy");

  a_one_solenoid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.front_drive && out_data_o.chip_drive))
    else $error("both solenoids driven");

  a_no_charge_in_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pulse_busy |-> !out_data_o.charge_on)
    else $error("charger on during pulse");

  a_step_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("evaluated beat did not reach result register");
`endif

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the kicker controller: random ticks vs. a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import kcfc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  item_t                  in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  result_t                out_data;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx = CFG_BALL_IR_LEVEL;
  logic [CfgDataBits-1:0] cfg_wdata = '0;

  kicker_charge_and_fire_control i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow of the controller: registers and tick state
  cfg_t                cfg_sh = '{BallIrLevelRst, MinFireLoadRst, MaxChargeLoadRst,
                                  CooldownRst, PulseUnitRst};
  logic                req_front = 1'b0;
  logic                req_chip = 1'b0;
  logic                req_charge = 1'b0;
  logic                req_bypass = 1'b0;
  logic [StrBits-1:0]  req_strength = '0;
  logic [CdBits-1:0]   since_kick = '0;
  logic [PulseBits-1:0] pulse_left = '0;
  logic                pulse_front = 1'b0;

  item_t       tick_q[$];
  result_t     predicted_q[$];
  int unsigned err_count = 0;
  int unsigned rx_count = 0;
  int unsigned tx_hold = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_calm = 0;

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic cmp_field(string name, logic got, logic want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %b want %b", rx_count, name, got, want));
  endtask

  // one tick of the controller; updates the shadow state
  function automatic result_t kick_predict(item_t it);
    result_t              r;
    logic [CdBits-1:0]    cd_was;
    logic [StrBits-1:0]   s;
    logic [ProdBits-1:0]  prod;
    logic [PulseBits-1:0] len;
    logic                 may_fire;
    r = '0;
    r.ball_seen = it.ir_sample < cfg_sh.ball_ir_level;
    cd_was = since_kick;
    if (it.cmd_valid) begin
      req_front = it.cmd_front;
      req_chip = it.cmd_chip;
      req_charge = it.cmd_charge;
      req_bypass = it.cmd_bypass_ir;
      req_strength = it.cmd_strength;
    end
    if (since_kick != '1) since_kick = since_kick + 1'b1;
    if (pulse_left != '0) begin
      r.pulse_busy = 1'b1;
      r.front_drive = pulse_front;
      r.chip_drive = !pulse_front;
      pulse_left = pulse_left - 1'b1;
    end else if (req_front || req_chip) begin
      may_fire = (r.ball_seen || req_bypass) && it.load_sample > cfg_sh.min_fire_load &&
                 cd_was > cfg_sh.cooldown_ticks;
      if (may_fire) begin
        s = (req_strength < StrOne) ? StrOne : req_strength;
        prod = ProdBits'(s) * ProdBits'(cfg_sh.pulse_unit_ticks);
        len = prod[ProdBits-1:4];
        pulse_front = req_front;
        r.kick_fired = 1'b1;
        r.pulse_busy = 1'b1;
        r.front_drive = pulse_front;
        r.chip_drive = !pulse_front;
        pulse_left = (len != '0) ? len - 1'b1 : '0;
        since_kick = '0;
        req_front = 1'b0;
        req_chip = 1'b0;
        req_charge = 1'b0;
      end else begin
        r.charge_on = it.load_sample < cfg_sh.max_charge_load;
      end
    end else if (req_charge) begin
      r.charge_on = it.load_sample < cfg_sh.max_charge_load;
    end
    return r;
  endfunction

  // mostly no gap, some short, a few long, and now and then a calm stretch
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: one beat per free slot, gaps drawn after each beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_q.push_back(kick_predict(in_data));
      if (!in_valid || !in_stall) begin
        if (tx_hold != 0) begin
          tx_hold--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_data <= tick_q.pop_front();
          in_valid <= 1'b1;
          tx_hold = idle_len(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    int unsigned n;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing predicted", rx_count));
        end else begin
          want = predicted_q.pop_front();
          cmp_field("charge_on", out_data.charge_on, want.charge_on);
          cmp_field("front_drive", out_data.front_drive, want.front_drive);
          cmp_field("chip_drive", out_data.chip_drive, want.chip_drive);
          cmp_field("ball_seen", out_data.ball_seen, want.ball_seen);
          cmp_field("kick_fired", out_data.kick_fired, want.kick_fired);
          cmp_field("pulse_busy", out_data.pulse_busy, want.pulse_busy);
        end
        rx_count++;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        n = idle_len(rx_calm);
        out_stall <= (n != 0);
        if (n != 0) rx_hold = n - 1;
      end
    end
  end

  function automatic item_t mk(int v, int f, int c, int chg, int byp,
                               logic [StrBits-1:0] str, logic [AdcBits-1:0] ir,
                               logic [AdcBits-1:0] load);
    item_t it;
    it.cmd_valid = v[0];
    it.cmd_front = f[0];
    it.cmd_chip = c[0];
    it.cmd_charge = chg[0];
    it.cmd_bypass_ir = byp[0];
    it.cmd_strength = str;
    it.ir_sample = ir;
    it.load_sample = load;
    return it;
  endfunction

  // ADC value: anywhere, around a threshold, or near either end
  function automatic logic [AdcBits-1:0] adc_pick(int center);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 4095);
      1: v = center + int'($urandom_range(0, 6)) - 3;
      2: v = $urandom_range(0, 100);
      default: v = 4095 - int'($urandom_range(0, 100));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[AdcBits-1:0];
  endfunction

  function automatic item_t rand_tick();
    item_t it;
    it = '0;
    it.ir_sample = adc_pick(int'(cfg_sh.ball_ir_level));
    it.load_sample = adc_pick($urandom_range(0, 1) ? int'(cfg_sh.min_fire_load)
                                                   : int'(cfg_sh.max_charge_load));
    if ($urandom_range(0, 9) == 0) begin
      it.cmd_valid = 1'b1;
      it.cmd_front = $urandom_range(0, 1) != 0;
      it.cmd_chip = $urandom_range(0, 1) != 0;
      it.cmd_charge = $urandom_range(0, 3) == 0;
      it.cmd_bypass_ir = $urandom_range(0, 1) != 0;
      it.cmd_strength = ($urandom_range(0, 3) == 0) ? StrBits'($urandom_range(0, 255))
                                                    : StrBits'($urandom_range(0, 40));
    end else if ($urandom_range(0, 9) == 0) begin
      // junk in the command fields without cmd_valid must be ignored
      it.cmd_front = $urandom_range(0, 1) != 0;
      it.cmd_chip = $urandom_range(0, 1) != 0;
      it.cmd_charge = $urandom_range(0, 1) != 0;
      it.cmd_bypass_ir = $urandom_range(0, 1) != 0;
      it.cmd_strength = StrBits'($urandom_range(0, 255));
    end
    return it;
  endfunction

  task automatic queue_ticks(int unsigned count);
    repeat (count) tick_q.push_back(rand_tick());
  endtask

  // block is idle once every queued tick went in and every result came back
  task automatic settle();
    while (tick_q.size() != 0 || in_valid || predicted_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CfgDataBits'(val);
    case (idx)
      CFG_BALL_IR_LEVEL:   cfg_sh.ball_ir_level = AdcBits'(val);
      CFG_MIN_FIRE_LOAD:   cfg_sh.min_fire_load = AdcBits'(val);
      CFG_MAX_CHARGE_LOAD: cfg_sh.max_charge_load = AdcBits'(val);
      CFG_COOLDOWN_TICKS:  cfg_sh.cooldown_ticks = CdBits'(val);
      CFG_PULSE_UNIT:      cfg_sh.pulse_unit_ticks = UnitBits'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned thr, int unsigned min_l, int unsigned max_l,
                            int unsigned cd, int unsigned unit);
    cfg_write(CFG_BALL_IR_LEVEL, thr);
    cfg_write(CFG_MIN_FIRE_LOAD, min_l);
    cfg_write(CFG_MAX_CHARGE_LOAD, max_l);
    cfg_write(CFG_COOLDOWN_TICKS, cd);
    cfg_write(CFG_PULSE_UNIT, unit);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned lo;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: threshold edges, charge stop edge, long cooldown blocks the kick
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd2047, 12'd0));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd2048, 12'd0));
    tick_q.push_back(mk(1, 0, 0, 1, 0, 8'd0, 12'd4095, 12'd3071));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd4095, 12'd3072));
    tick_q.push_back(mk(1, 1, 0, 0, 1, 8'd17, 12'd0, 12'd4095));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd0, 12'd0));
    tick_q.push_back(mk(0, 1, 1, 1, 1, 8'hff, 12'd4095, 12'd4095));
    settle();

    // unit 1: Q4.4 truncation to single ticks, load edge, front over chip,
    // command latched during a pulse, cancel
    set_config(2048, 1000, 4000, 0, 1);
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd4095, 12'd1000));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd4095, 12'd1001));
    tick_q.push_back(mk(1, 1, 1, 0, 0, 8'd0, 12'd2047, 12'd4095));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd2047, 12'd4095));
    tick_q.push_back(mk(1, 0, 1, 0, 0, 8'd48, 12'd4095, 12'd4095));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd0, 12'd4095));
    tick_q.push_back(mk(1, 1, 0, 0, 1, 8'd0, 12'd4095, 12'd4095));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd4095, 12'd4095));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd4095, 12'd4095));
    tick_q.push_back(mk(1, 0, 0, 0, 0, 8'd0, 12'd0, 12'd0));
    tick_q.push_back(mk(0, 0, 0, 0, 0, 8'd0, 12'd0, 12'd0));
    settle();

    // zero pulse unit: every kick is a single tick
    set_config($urandom_range(800, 3000), $urandom_range(0, 2000), $urandom_range(1000, 4095),
               $urandom_range(0, 20), 0);
    queue_ticks(250);
    settle();

    // nothing seen, nothing fires, nothing charges
    set_config(0, 4095, 0, 0, 1);
    queue_ticks(150);
    settle();

    // most ticks seen and charging, but the cooldown never runs out
    set_config(4095, 0, 4095, 24'hfffffe, 1);
    queue_ticks(150);
    settle();

    repeat (4) begin
      lo = $urandom_range(0, 2500);
      set_config($urandom_range(300, 3800), lo, $urandom_range(lo, 4095),
                 $urandom_range(0, 40), $urandom_range(1, 16));
      queue_ticks(300);
      settle();
    end

    // widest pulse unit: one kick keeps the solenoid busy to the end
    set_config($urandom_range(1000, 3000), 0, 4095, 0, 16'hffff);
    queue_ticks(200);
    settle();

    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(8 * 3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
